// File: rtl/srrw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the selective-repeat receive window
package srrw_pkg;

  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned KIND_W    = 8;
  localparam int unsigned CFG_WIN_W = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [KIND_W-1:0]    FRAME_KIND_DATA = 8'd3;
  localparam logic [CFG_WIN_W-1:0] WIN_RESET       = 5'd16;
  localparam logic [APB_AW-1:0]    ADDR_WINDOW     = 3'd0;

  typedef enum logic [1:0] {
    RES_DELIVER = 2'd0,
    RES_RR      = 2'd1,
    RES_SREJ    = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq_num;
    logic [HANDLE_W-1:0] payload_handle;
    logic [LEN_W-1:0]    payload_len;
    logic [KIND_W-1:0]   frame_kind;
    logic                checksum_ok;
  } frame_t;

  typedef struct packed {
    res_kind_e           result_kind;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEN_W-1:0]    out_len;
    logic [SEQ_W-1:0]    report_seq;
    logic [SEQ_W-1:0]    control_count;
    logic                last;
  } result_t;

  // one parked frame in the slot memory
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } slot_t;

endpackage

// File: rtl/selective_repeat_receive_window.sv
`timescale 1ns / 1ps
// selective-repeat receive window: reorder slot memory, flush and control reporting
//
//   channel   ports                               transfer
//   -------   ---------------------------------   -----------------------------------
//   frame     start, busy, frame_i                start high and busy low at clk edge
//   result    res_strobe_o, result_o              one cycle, strobe high, no stall
//   config    psel, penable, pwrite, paddr, ...   psel & penable & pwrite (pready=1)
//
// steps: a dropped frame is ignored; an in-order or old frame has a transfer, then
// a control result. a parked frame runs the remainder unit, a slot write and the
// control result; a buffering-mode in-sequence frame runs the transfer, the remainder
// unit, the flush checks and the control result. the sequence-to-slot remainder unit
// works 4 bits a cycle, and each flush check is a slot memory read followed by a
// check, the last check finding no match unless the window limit stops it.
// reset: asynchronous, active low; clears mode, counters and all slot valid bits
// at once, no clearing pass. results cannot be stalled; busy covers all work.

module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // frame input
  input  logic                start,
  output logic                busy,
  input  frame_t              frame_i,
  // results
  output logic                res_strobe_o,
  output result_t             result_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  // slot index width and a width that holds the window itself
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned RW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW     = RW + 4;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MOD    = 6'b000010,
    S_PARK   = 6'b000100,
    S_FL_RD  = 6'b001000,
    S_FL_CHK = 6'b010000,
    S_CTRL   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_WIN_W-1:0]  win_q;
  logic                  mode_q, mode_d;           // 1: buffering mode
  logic [SEQ_W-1:0]      ne_q, ne_d;               // next expected
  logic [SEQ_W-1:0]      hs_q, hs_d;               // highest seen
  logic [SEQ_W-1:0]      cc_q, cc_d;               // control counter
  logic [MAX_WINDOW-1:0] valid_q, valid_d;

  // working copy of the current frame
  logic [SEQ_W-1:0]      seq_q, seq_d;
  logic [HANDLE_W-1:0]   hdl_q, hdl_d;
  logic [LEN_W-1:0]      len_q, len_d;

  // remainder unit, one nibble per cycle from the top
  logic [SEQ_W-1:0]      div_q, div_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [2:0]            nib_q, nib_d;
  logic [RW-1:0]         rem_step;

  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [RW-1:0]         steps_q, steps_d;
  logic                  park_q, park_d;           // remainder feeds park, else flush
  logic                  srej_q, srej_d;
  logic                  flush_q, flush_d;         // control kind follows the flush

  logic                  res_strobe_q, res_strobe_d;
  result_t               res_q, res_d;

  // slot memory, one read or one write a cycle, registered read data
  slot_t                 mem_q [MAX_WINDOW];
  slot_t                 rd_q;
  logic                  mem_we, mem_re;
  slot_t                 mem_wd;

  logic [RW-1:0]         w_eff;
  logic                  cfg_wr;
  logic                  srej_now;

  // effective window: zero acts as one, clamp at MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      w_eff = RW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      w_eff = RW'(MAX_WINDOW);
    end else begin
      w_eff = RW'(win_q);
    end
  end

  // next slot after the one of sq, wrapping at the window and at 2^32
  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s,
                                                  input logic [SEQ_W-1:0]  sq,
                                                  input logic [RW-1:0]     w);
    logic [RW:0] p;
    p = (RW + 1)'(s) + (RW + 1)'(1);
    if (&sq) begin
      return '0;
    end else if (p == {1'b0, w}) begin
      return '0;
    end else begin
      return SLOT_W'(p);
    end
  endfunction

  // one nibble of restoring remainder: four compare-subtract steps
  always_comb begin : rem_unit
    logic [TW-1:0] t;
    logic [TW-1:0] wk;
    t = {rem_q, div_q[SEQ_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      wk = TW'(w_eff) << k;
      if (t >= wk) begin
        t = t - wk;
      end
    end
    rem_step = RW'(t);
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW);

  always_comb begin
    if (paddr == ADDR_WINDOW) begin
      prdata = APB_DW'(win_q);
    end else begin
      prdata = '0;
    end
  end

  assign srej_now = flush_q ? (ne_q <= hs_q) : srej_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    ne_d         = ne_q;
    hs_d         = hs_q;
    cc_d         = cc_q;
    valid_d      = valid_q;
    seq_d        = seq_q;
    hdl_d        = hdl_q;
    len_d        = len_q;
    div_d        = div_q;
    rem_d        = rem_q;
    nib_d        = nib_q;
    slot_d       = slot_q;
    steps_d      = steps_q;
    park_d       = park_q;
    srej_d       = srej_q;
    flush_d      = flush_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wd       = '{seq: seq_q, handle: hdl_q, len: len_q};

    case (state_q)
      S_IDLE: begin
        if (start && frame_i.checksum_ok && frame_i.frame_kind == FRAME_KIND_DATA) begin
          seq_d   = frame_i.seq_num;
          hdl_d   = frame_i.payload_handle;
          len_d   = frame_i.payload_len;
          div_d   = frame_i.seq_num;
          rem_d   = '0;
          nib_d   = '0;
          steps_d = '0;
          flush_d = 1'b0;
          srej_d  = 1'b0;
          if (frame_i.seq_num == ne_q) begin
            // expected frame goes out right away
            res_strobe_d = 1'b1;
            res_d = '{result_kind: RES_DELIVER, out_handle: frame_i.payload_handle,
                      out_len: frame_i.payload_len, report_seq: '0,
                      control_count: '0, last: 1'b0};
            ne_d = ne_q + 1'b1;
            if (!mode_q) begin
              hs_d    = ne_q;
              state_d = S_CTRL;
            end else begin
              park_d  = 1'b0;
              state_d = S_MOD;
            end
          end else if (frame_i.seq_num > ne_q) begin
            park_d  = 1'b1;
            state_d = S_MOD;
          end else begin
            // old frame: plain RR
            state_d = S_CTRL;
          end
        end
      end

      S_MOD: begin
        div_d = div_q << 4;
        rem_d = rem_step;
        nib_d = nib_q + 3'd1;
        if (&nib_q) begin
          if (park_q) begin
            slot_d  = SLOT_W'(rem_step);
            state_d = S_PARK;
          end else begin
            slot_d  = slot_next(SLOT_W'(rem_step), seq_q, w_eff);
            state_d = S_FL_RD;
          end
        end
      end

      S_PARK: begin
        mem_we          = 1'b1;
        valid_d[slot_q] = 1'b1;
        if (!mode_q || seq_q > hs_q) begin
          hs_d = seq_q;
        end
        mode_d  = 1'b1;
        srej_d  = 1'b1;
        state_d = S_CTRL;
      end

      S_FL_RD: begin
        mem_re  = 1'b1;
        state_d = S_FL_CHK;
      end

      S_FL_CHK: begin
        if (valid_q[slot_q] && rd_q.seq == ne_q) begin
          res_strobe_d = 1'b1;
          res_d = '{result_kind: RES_DELIVER, out_handle: rd_q.handle,
                    out_len: rd_q.len, report_seq: '0,
                    control_count: '0, last: 1'b0};
          valid_d[slot_q] = 1'b0;
          ne_d    = ne_q + 1'b1;
          slot_d  = slot_next(slot_q, ne_q, w_eff);
          steps_d = steps_q + 1'b1;
          if ((RW + 1)'(steps_q) + (RW + 1)'(1) < (RW + 1)'(w_eff)) begin
            state_d = S_FL_RD;
          end else begin
            flush_d = 1'b1;
            state_d = S_CTRL;
          end
        end else begin
          flush_d = 1'b1;
          state_d = S_CTRL;
        end
      end

      S_CTRL: begin
        res_strobe_d = 1'b1;
        res_d = '{result_kind: srej_now ? RES_SREJ : RES_RR, out_handle: '0,
                  out_len: '0, report_seq: ne_q, control_count: cc_q, last: 1'b1};
        cc_d = cc_q + 1'b1;
        if (flush_q && !srej_now) begin
          mode_d = 1'b0;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      win_q        <= WIN_RESET;
      mode_q       <= 1'b0;
      ne_q         <= '0;
      hs_q         <= '0;
      cc_q         <= '0;
      valid_q      <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      ne_q         <= ne_d;
      hs_q         <= hs_d;
      cc_q         <= cc_d;
      valid_q      <= valid_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_wr) begin
        win_q <= pwdata[CFG_WIN_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    hdl_q   <= hdl_d;
    len_q   <= len_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    nib_q   <= nib_d;
    slot_q  <= slot_d;
    steps_q <= steps_d;
    park_q  <= park_d;
    srej_q  <= srej_d;
    flush_q <= flush_d;
    res_q   <= res_d;
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[slot_q];
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign result_o     = res_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PARK || state_q == S_FL_RD) |-> (RW'(slot_q) < w_eff))
    else $error("slot index outside the window");

  a_ctrl_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.result_kind != RES_DELIVER) |->
      (result_o.out_handle == '0 && result_o.out_len == '0 && result_o.last))
    else $error("control result carries payload or is not last");

  a_deliver_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.result_kind == RES_DELIVER) |-> !result_o.last)
    else $error("deliver result marked last");

  a_ctrl_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.last) |-> (cc_q == result_o.control_count + 1'b1))
    else $error("control counter did not advance with the control result");

endmodule
